>>> design/rcb_pkg.sv
// Shared types, codes and widths for the row convolution backward block.
// Depends on nothing; every other file of the block but rcb_ram imports it.
package rcb_pkg;

    localparam int DEF_MAX_CONTEXT  = 16;
    localparam int DEF_MAX_CHANNELS = 256;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int DX_W     = 36;
    localparam int ACC_W    = 48;
    localparam int CTX_W    = 5;
    localparam int FUNC_W   = 2;
    localparam int KIND_W   = 2;
    localparam int TAPF_W   = 4;
    localparam int CHF_W    = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DX  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DW  = 2'd2;

    // Control handed from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;     // memory read data for one tap is present
        logic first;     // tap 0 uses the incoming gradient, not the history
        logic clr_sum;   // start a new input-gradient sum
    } t_mac_ctl;

endpackage

>>> design/rcb_in_if.sv
// Request channel of the row convolution backward block.
// Depends on rcb_pkg for the field widths.
interface rcb_in_if;
    import rcb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [TAPF_W-1:0]          tap;
    logic [CHF_W-1:0]           channel;
    logic                       seq_start;
    logic signed [SAMPLE_W-1:0] x_val;
    logic signed [SAMPLE_W-1:0] dout_val;
    logic signed [SAMPLE_W-1:0] weight_val;

    modport source (output valid, func, tap, channel, seq_start, x_val, dout_val,
                    weight_val, input ready);
    modport sink (input valid, func, tap, channel, seq_start, x_val, dout_val,
                  weight_val, output ready);
endinterface

>>> design/rcb_out_if.sv
// Response channel of the row convolution backward block.
// Depends on rcb_pkg for the field widths.
interface rcb_out_if;
    import rcb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [DX_W-1:0]  dx_val;
    logic signed [ACC_W-1:0] dw_val;

    modport source (output valid, kind, dx_val, dw_val, input ready);
    modport sink (input valid, kind, dx_val, dw_val, output ready);
endinterface

>>> design/rcb_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module rcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/rcb_mac.sv
// Two-stage multiply-accumulate unit: products, then the input-gradient sum and
// the saturating weight-gradient update. Depends on rcb_pkg.
module rcb_mac #(
    parameter int TW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rcb_pkg::t_mac_ctl                 i_ctl,
    input  logic [TW-1:0]                     i_w,
    input  logic signed [rcb_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [rcb_pkg::SAMPLE_W-1:0] i_dout,
    input  logic signed [rcb_pkg::SAMPLE_W-1:0] i_tap,
    input  logic signed [rcb_pkg::SAMPLE_W-1:0] i_hist,
    input  logic signed [rcb_pkg::ACC_W-1:0]    i_acc,
    output logic                              o_acc_we,
    output logic [TW-1:0]                     o_acc_w,
    output logic signed [rcb_pkg::ACC_W-1:0]    o_acc_wdata,
    output logic signed [rcb_pkg::DX_W-1:0]     o_sum,
    output logic                              o_busy
);
    import rcb_pkg::*;

    logic                       r_valid;
    logic [TW-1:0]              r_w;
    logic signed [PROD_W-1:0]   r_prod_t;
    logic signed [PROD_W-1:0]   r_prod_x;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DX_W-1:0]     r_sum;
    logic signed [DX_W-1:0]     n_sum;
    logic signed [SAMPLE_W-1:0] d;
    logic signed [ACC_W:0]      acc_ext;

    assign d = i_ctl.first ? i_dout : i_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_w      <= i_w;
        r_prod_t <= i_tap * d;
        r_prod_x <= i_x * d;
        r_acc    <= i_acc;
        r_sum    <= n_sum;
    end

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clr_sum) begin
            n_sum = '0;
        end else if (r_valid) begin
            n_sum = r_sum + DX_W'(r_prod_t);
        end
    end

    // One guard bit shows whether the 48-bit accumulator left its range.
    always_comb begin
        acc_ext = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_prod_x);
        if (acc_ext[ACC_W] != acc_ext[ACC_W-1]) begin
            o_acc_wdata = acc_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            o_acc_wdata = acc_ext[ACC_W-1:0];
        end
    end

    assign o_acc_we = r_valid;
    assign o_acc_w  = r_w;
    assign o_sum    = r_sum;
    assign o_busy   = r_valid;
endmodule

>>> design/row_conv_backward.sv
// Top level of the row convolution backward block: sequencer, stores and
// output register. Depends on rcb_pkg, rcb_in_if, rcb_out_if, rcb_ram, rcb_mac.
//
//  Channel   Dir  Handshake       Payload
//  i_req     in   valid/ready     func, tap, channel, seq_start, x_val,
//                                 dout_val, weight_val
//  o_rsp     out  valid/ready     kind, dx_val, dw_val
//  config    in   i_cfg_we        i_cfg_wdata (context_len)
//
// A data request steps through n taps, n being the number of taps in use
// (at most the context length); the tap, history and gradient memories
// give one entry per cycle to a single multiply-accumulate unit. A clear of
// all weight gradients sweeps the gradient memory one entry a cycle, and the
// same sweep (which also clears the per-channel fill counts) runs after
// reset before the first request is taken. A finished response waits in the
// output register, so the next request is accepted while it is held.
module row_conv_backward #(
    parameter int MAX_CONTEXT  = rcb_pkg::DEF_MAX_CONTEXT,
    parameter int MAX_CHANNELS = rcb_pkg::DEF_MAX_CHANNELS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [rcb_pkg::CTX_W-1:0] i_cfg_wdata,
    rcb_in_if.sink                   i_req,
    rcb_out_if.source                o_rsp
);
    import rcb_pkg::*;

    // Tap index width, channel index width and the address of a tap/channel
    // entry; the history keeps 2^TW slots per channel as a ring.
    localparam int TW = (MAX_CONTEXT > 1) ? $clog2(MAX_CONTEXT) : 1;
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW = TW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHRD  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_RDW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                 r_state, n_state;
    logic [CTX_W-1:0]           r_ctx;
    logic [AW-1:0]              r_clr_idx, n_clr_idx;
    logic                       r_clr_rst, n_clr_rst;
    logic [CW-1:0]              r_ch, n_ch;
    logic                       r_ok, n_ok;
    logic                       r_start, n_start;
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic signed [SAMPLE_W-1:0] r_dout, n_dout;
    logic [TW-1:0]              r_w, n_w;
    logic [TW-1:0]              r_last_w, n_last_w;
    logic [TW-1:0]              r_ptr, n_ptr;
    logic                       r_p1_valid, n_p1_valid;
    logic                       r_p1_first, n_p1_first;
    logic [TW-1:0]              r_p1_w, n_p1_w;
    logic [KIND_W-1:0]          r_res_kind, n_res_kind;
    logic signed [DX_W-1:0]     r_res_dx, n_res_dx;
    logic signed [ACC_W-1:0]    r_res_dw, n_res_dw;
    logic                       r_ovalid, n_ovalid;
    logic [KIND_W-1:0]          r_okind, n_okind;
    logic signed [DX_W-1:0]     r_odx, n_odx;
    logic signed [ACC_W-1:0]    r_odw, n_odw;

    logic                       accept;
    logic                       ch_ok, tap_ok;
    logic [CW-1:0]              in_ch;
    logic [TW-1:0]              in_tap;

    logic                       tap_we;
    logic [SAMPLE_W-1:0]        tap_rdata;
    logic                       hist_we;
    logic [SAMPLE_W-1:0]        hist_rdata;
    logic                       acc_we;
    logic [AW-1:0]              acc_waddr, acc_raddr;
    logic [ACC_W-1:0]           acc_wdata, acc_rdata;
    logic                       chan_we;
    logic [CW-1:0]              chan_waddr;
    logic [2*TW-1:0]            chan_wdata, chan_rdata;

    t_mac_ctl                   mac_ctl;
    logic                       mac_we;
    logic [TW-1:0]              mac_w;
    logic signed [ACC_W-1:0]    mac_wdata;
    logic signed [DX_W-1:0]     mac_sum;
    logic                       mac_busy;

    // Per-channel state read at the start of a data request.
    logic [TW-1:0]              ch_fill, ch_ptr, fill_eff, fill_next;
    logic [7:0]                 act8, avail8, n8;

    assign in_ch  = CW'(i_req.channel);
    assign in_tap = TW'(i_req.tap);
    assign ch_ok  = 16'(i_req.channel) < 16'(MAX_CHANNELS);
    assign tap_ok = 8'(i_req.tap) < 8'(MAX_CONTEXT);

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // Context length 0 acts as one tap, and lengths beyond the store saturate.
    always_comb begin
        if (r_ctx == '0) begin
            act8 = 8'd1;
        end else if (8'(r_ctx) > 8'(MAX_CONTEXT)) begin
            act8 = 8'(MAX_CONTEXT);
        end else begin
            act8 = 8'(r_ctx);
        end
    end

    assign ch_fill   = chan_rdata[2*TW-1:TW];
    assign ch_ptr    = chan_rdata[TW-1:0];
    assign fill_eff  = r_start ? '0 : ch_fill;
    assign avail8    = 8'(fill_eff) + 8'd1;
    assign n8        = (act8 > avail8) ? avail8 : act8;
    assign fill_next = (8'(fill_eff) < 8'(MAX_CONTEXT - 1)) ? fill_eff + TW'(1) : fill_eff;

    // Stores. Taps are written straight from an accepted load request.
    assign tap_we = accept && (i_req.func == FUNC_LOAD) && ch_ok && tap_ok;

    rcb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr ({in_tap, in_ch}),
        .i_wdata (i_req.weight_val),
        .i_raddr ({r_w, r_ch}),
        .o_rdata (tap_rdata)
    );

    // The history is a ring per channel: the newest gradient goes to the slot
    // at the pointer, and the gradient w steps back sits w slots behind it.
    assign hist_we = (r_state == S_CHRD);

    rcb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr ({ch_ptr, r_ch}),
        .i_wdata (r_dout),
        .i_raddr ({r_ptr - r_w, r_ch}),
        .o_rdata (hist_rdata)
    );

    // Gradient memory: cleared by the sweep, otherwise written by the unit.
    always_comb begin
        if (r_state == S_CLEAR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr_idx;
            acc_wdata = '0;
        end else begin
            acc_we    = mac_we;
            acc_waddr = {mac_w, r_ch};
            acc_wdata = mac_wdata;
        end
        acc_raddr = (r_state == S_IDLE) ? {in_tap, in_ch} : {r_w, r_ch};
    end

    rcb_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // Fill count and ring pointer per channel; only the reset sweep clears it.
    always_comb begin
        if (r_state == S_CLEAR) begin
            chan_we    = r_clr_rst;
            chan_waddr = r_clr_idx[CW-1:0];
            chan_wdata = '0;
        end else begin
            chan_we    = (r_state == S_CHRD);
            chan_waddr = r_ch;
            chan_wdata = {fill_next, ch_ptr + TW'(1)};
        end
    end

    rcb_ram #(.WIDTH(2*TW), .DEPTH(1 << CW)) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (chan_we),
        .i_waddr (chan_waddr),
        .i_wdata (chan_wdata),
        .i_raddr (in_ch),
        .o_rdata (chan_rdata)
    );

    assign mac_ctl.valid   = r_p1_valid;
    assign mac_ctl.first   = r_p1_first;
    assign mac_ctl.clr_sum = (r_state == S_CHRD);

    rcb_mac #(.TW(TW)) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_w         (r_p1_w),
        .i_x         (r_x),
        .i_dout      (r_dout),
        .i_tap       (tap_rdata),
        .i_hist      (hist_rdata),
        .i_acc       (acc_rdata),
        .o_acc_we    (mac_we),
        .o_acc_w     (mac_w),
        .o_acc_wdata (mac_wdata),
        .o_sum       (mac_sum),
        .o_busy      (mac_busy)
    );

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_clr_rst  = r_clr_rst;
        n_ch       = r_ch;
        n_ok       = r_ok;
        n_start    = r_start;
        n_x        = r_x;
        n_dout     = r_dout;
        n_w        = r_w;
        n_last_w   = r_last_w;
        n_ptr      = r_ptr;
        n_p1_valid = 1'b0;
        n_p1_first = 1'b0;
        n_p1_w     = r_w;
        n_res_kind = r_res_kind;
        n_res_dx   = r_res_dx;
        n_res_dw   = r_res_dw;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(DEPTH - 1)) begin
                    n_state = r_clr_rst ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_ch       = in_ch;
                    n_start    = i_req.seq_start;
                    n_x        = i_req.x_val;
                    n_dout     = i_req.dout_val;
                    n_ok       = ch_ok && tap_ok;
                    n_res_kind = KIND_ACK;
                    n_res_dx   = '0;
                    n_res_dw   = '0;
                    unique case (i_req.func)
                        FUNC_LOAD: begin
                            n_state = S_DONE;
                        end
                        FUNC_DATA: begin
                            n_res_kind = KIND_DX;
                            n_state    = ch_ok ? S_CHRD : S_DONE;
                        end
                        FUNC_READ: begin
                            n_res_kind = KIND_DW;
                            n_state    = S_RDW;
                        end
                        FUNC_CLEAR: begin
                            n_clr_idx = '0;
                            n_clr_rst = 1'b0;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHRD: begin
                // The pointer stays on the slot that now holds this gradient.
                n_ptr    = ch_ptr;
                n_last_w = TW'(n8 - 8'd1);
                n_w      = '0;
                n_state  = S_RUN;
            end
            S_RUN: begin
                n_p1_valid = 1'b1;
                n_p1_first = (r_w == '0);
                n_p1_w     = r_w;
                n_w        = r_w + TW'(1);
                if (r_w == r_last_w) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_valid && !mac_busy) begin
                    n_res_dx = mac_sum;
                    n_state  = S_DONE;
                end
            end
            S_RDW: begin
                n_res_dw = r_ok ? acc_rdata : '0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the finished result, held until taken.
    always_comb begin
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_okind  = r_okind;
        n_odx    = r_odx;
        n_odw    = r_odw;
        if ((r_state == S_DONE) && (!r_ovalid || o_rsp.ready)) begin
            n_ovalid = 1'b1;
            n_okind  = r_res_kind;
            n_odx    = r_res_dx;
            n_odw    = r_res_dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_clr_rst  <= 1'b1;
            r_ctx      <= CTX_W'(1);
            r_p1_valid <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_clr_rst  <= n_clr_rst;
            if (i_cfg_we) begin
                r_ctx <= i_cfg_wdata;
            end
            r_p1_valid <= n_p1_valid;
            r_ovalid   <= n_ovalid;
        end
        r_ch       <= n_ch;
        r_ok       <= n_ok;
        r_start    <= n_start;
        r_x        <= n_x;
        r_dout     <= n_dout;
        r_w        <= n_w;
        r_last_w   <= n_last_w;
        r_ptr      <= n_ptr;
        r_p1_first <= n_p1_first;
        r_p1_w     <= n_p1_w;
        r_res_kind <= n_res_kind;
        r_res_dx   <= n_res_dx;
        r_res_dw   <= n_res_dw;
        r_okind    <= n_okind;
        r_odx      <= n_odx;
        r_odw      <= n_odw;
    end

    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.kind   = r_okind;
    assign o_rsp.dx_val = r_odx;
    assign o_rsp.dw_val = r_odw;
endmodule
